[hw/rtl/key_press_event_detector_defines.svh]
// Assertion macros for the key press event detector.
`ifndef KEY_PRESS_EVENT_DETECTOR_DEFINES_SVH
`define KEY_PRESS_EVENT_DETECTOR_DEFINES_SVH

// Checked outside reset.
`define KPED_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every edge, reset included.
`define KPED_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hw/rtl/kped_pkg.sv]
package kped_pkg;

   localparam int unsigned KEY_W   = 8;
   localparam int unsigned CMD_W   = 3;
   localparam int unsigned REG_W   = 8;
   localparam int unsigned PRESS_W = 16;
   localparam int unsigned CSR_IDX_W = 2;

   typedef enum logic [CMD_W-1:0] {
      CMD_SCAN       = 3'd0,
      CMD_ARM_DOUBLE = 3'd1,
      CMD_ARM_LONG   = 3'd2,
      CMD_EN_RELEASE = 3'd3,
      CMD_ACK        = 3'd4
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HOLD_RELOAD   = 2'd0,
      CSR_FIRST_REPEAT  = 2'd1,
      CSR_DOUBLE_WINDOW = 2'd2,
      CSR_TICKS_PER_SEC = 2'd3
   } csr_index_type;

   localparam logic [REG_W-1:0] HOLD_RELOAD_RST   = 8'd50;
   localparam logic [REG_W-1:0] FIRST_REPEAT_RST  = 8'd10;
   localparam logic [REG_W-1:0] DOUBLE_WINDOW_RST = 8'd100;
   localparam logic [REG_W-1:0] TICKS_PER_SEC_RST = 8'd50;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [KEY_W-1:0] key_code;
      logic [7:0]       long_seconds;
   } req_type;

   typedef struct packed {
      logic [KEY_W-1:0] active_key;
      logic             key_event;
      logic             long_event;
      logic             double_event;
      logic             release_event;
      logic             key_down;
      logic             repeat_mark;
   } rsp_type;

   typedef struct packed {
      logic                 wr_en;
      logic [CSR_IDX_W-1:0] index;
      logic [REG_W-1:0]     data;
   } csr_wr_type;

endpackage

[hw/rtl/kped_core.sv]
module kped_core (
   input  logic               clock,
   input  logic               reset,
   input  kped_pkg::csr_wr_type csr,
   input  logic               step,
   input  kped_pkg::req_type  req,
   output kped_pkg::rsp_type  rsp
);
   import kped_pkg::*;

   logic [REG_W-1:0] hold_reload_ff, first_repeat_ff, double_window_ff, ticks_per_sec_ff;

   logic [REG_W-1:0]   hold_ff, hold_in;
   logic [REG_W-1:0]   dbl_ff, dbl_in;
   logic [PRESS_W-1:0] press_ff, press_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic ev_key_ff, ev_key_in, ev_long_ff, ev_long_in, ev_dbl_ff, ev_dbl_in;
   logic ev_rel_ff, ev_rel_in, ev_mark_ff, ev_mark_in;
   logic md_long_ff, md_long_in, md_dbl_ff, md_dbl_in;
   logic md_rel_ff, md_rel_in, md_press_ff, md_press_in;
   logic [PRESS_W-1:0] long_time;

   assign long_time = PRESS_W'(req.long_seconds) * PRESS_W'(ticks_per_sec_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_reload_ff   <= HOLD_RELOAD_RST;
         first_repeat_ff  <= FIRST_REPEAT_RST;
         double_window_ff <= DOUBLE_WINDOW_RST;
         ticks_per_sec_ff <= TICKS_PER_SEC_RST;
      end else if (csr.wr_en) begin
         unique case (csr.index)
            CSR_HOLD_RELOAD:   hold_reload_ff   <= csr.data;
            CSR_FIRST_REPEAT:  first_repeat_ff  <= csr.data;
            CSR_DOUBLE_WINDOW: double_window_ff <= csr.data;
            CSR_TICKS_PER_SEC: ticks_per_sec_ff <= csr.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      hold_in     = hold_ff;
      dbl_in      = dbl_ff;
      press_in    = press_ff;
      key_in      = key_ff;
      ev_key_in   = ev_key_ff;
      ev_long_in  = ev_long_ff;
      ev_dbl_in   = ev_dbl_ff;
      ev_rel_in   = ev_rel_ff;
      ev_mark_in  = ev_mark_ff;
      md_long_in  = md_long_ff;
      md_dbl_in   = md_dbl_ff;
      md_rel_in   = md_rel_ff;
      md_press_in = md_press_ff;
      unique case (req.cmd)
         CMD_SCAN: begin
            if (hold_in != '0) hold_in = hold_in - 1'b1;
            if (dbl_in != '0) dbl_in = dbl_in - 1'b1;
            if (press_in != '0) begin
               press_in = press_in - 1'b1;
            end else begin
               md_long_in = 1'b0;
               md_dbl_in  = 1'b0;
               ev_mark_in = 1'b0;
            end
            if (hold_in == '0) begin
               md_long_in = 1'b0;
               ev_mark_in = 1'b0;
            end
            if (req.key_code == key_ff) begin
               if (req.key_code != '0) begin
                  md_press_in = 1'b1;
                  if (press_in == '0) begin
                     if (md_long_in) begin
                        ev_long_in = 1'b1;
                        ev_key_in  = 1'b1;
                        md_long_in = 1'b0;
                        md_rel_in  = 1'b0;
                     end else begin
                        ev_mark_in = 1'b1;
                        ev_key_in  = 1'b1;
                        press_in   = PRESS_W'(1);
                     end
                  end
                  hold_in = hold_reload_ff;
               end else begin
                  md_long_in = 1'b0;
               end
            end else begin
               md_long_in = 1'b0;
               if (req.key_code != '0) begin
                  md_press_in = 1'b1;
                  ev_rel_in   = 1'b0;
                  md_rel_in   = 1'b0;
                  if (md_dbl_in) begin
                     if (dbl_in != '0) begin
                        ev_dbl_in = 1'b1;
                        ev_key_in = 1'b1;
                        key_in    = req.key_code;
                        hold_in   = hold_reload_ff;
                        press_in  = PRESS_W'(first_repeat_ff);
                     end else begin
                        ev_dbl_in = 1'b0;   // swallowed press
                     end
                  end else begin
                     key_in     = req.key_code;
                     ev_key_in  = 1'b1;
                     ev_mark_in = 1'b0;
                     hold_in    = hold_reload_ff;
                     press_in   = PRESS_W'(first_repeat_ff);
                  end
               end else begin
                  if (md_rel_in) begin
                     if (md_press_in) begin
                        ev_rel_in = 1'b1;
                        ev_key_in = 1'b1;
                        md_rel_in = 1'b0;
                     end
                  end else begin
                     key_in = '0;
                  end
                  md_press_in = 1'b0;
               end
            end
         end
         CMD_ARM_DOUBLE: begin
            if (!md_dbl_ff) begin
               md_dbl_in = 1'b1;
               dbl_in    = double_window_ff;
            end
         end
         CMD_ARM_LONG: begin
            if (!md_long_ff) begin
               md_long_in = 1'b1;
               press_in   = long_time;
            end
         end
         CMD_EN_RELEASE: md_rel_in = 1'b1;
         CMD_ACK: begin
            ev_key_in  = 1'b0;
            ev_long_in = 1'b0;
            ev_dbl_in  = 1'b0;
            ev_rel_in  = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff     <= '0;
         dbl_ff      <= '0;
         press_ff    <= '0;
         key_ff      <= '0;
         ev_key_ff   <= 1'b0;
         ev_long_ff  <= 1'b0;
         ev_dbl_ff   <= 1'b0;
         ev_rel_ff   <= 1'b0;
         ev_mark_ff  <= 1'b0;
         md_long_ff  <= 1'b0;
         md_dbl_ff   <= 1'b0;
         md_rel_ff   <= 1'b0;
         md_press_ff <= 1'b0;
      end else if (step) begin
         hold_ff     <= hold_in;
         dbl_ff      <= dbl_in;
         press_ff    <= press_in;
         key_ff      <= key_in;
         ev_key_ff   <= ev_key_in;
         ev_long_ff  <= ev_long_in;
         ev_dbl_ff   <= ev_dbl_in;
         ev_rel_ff   <= ev_rel_in;
         ev_mark_ff  <= ev_mark_in;
         md_long_ff  <= md_long_in;
         md_dbl_ff   <= md_dbl_in;
         md_rel_ff   <= md_rel_in;
         md_press_ff <= md_press_in;
      end
   end

   assign rsp.active_key    = key_in;
   assign rsp.key_event     = ev_key_in;
   assign rsp.long_event    = ev_long_in;
   assign rsp.double_event  = ev_dbl_in;
   assign rsp.release_event = ev_rel_in;
   assign rsp.key_down      = md_press_in;
   assign rsp.repeat_mark   = ev_mark_in;

endmodule

[hw/rtl/key_press_event_detector.sv]
// channel   direction  ports                          payload
// request   in         req_valid, req_stall, req_data  kped_pkg::req_type
// response  out        rsp_valid, rsp_stall, rsp_data  kped_pkg::rsp_type
// csr       in         csr_wr_en, csr_index, csr_wr_data  8 bit registers
//
// One request per cycle while req_stall is low; the response goes through the input register
// and then the result register, from which it can be taken.
// The single step between them reads and updates the timer and flag registers.
// Synchronous reset clears all timers and flags and loads the register defaults.
// A stalled response holds; the input register keeps accepting until it too is full.
`include "key_press_event_detector_defines.svh"

module key_press_event_detector (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  kped_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output kped_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [kped_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kped_pkg::REG_W-1:0]      csr_wr_data
);
   import kped_pkg::*;

   logic       in_valid_ff;
   req_type    in_data_ff;
   logic       out_valid_ff;
   rsp_type    out_data_ff;
   rsp_type    step_rsp;
   csr_wr_type csr;
   logic       advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   assign csr.wr_en = csr_wr_en;
   assign csr.index = csr_index;
   assign csr.data  = csr_wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
   end

   kped_core u_core (
      .clock (clock),
      .reset (reset),
      .csr   (csr),
      .step  (advance),
      .req   (in_data_ff),
      .rsp   (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   `KPED_ASSERT(a_stall_needs_full, req_stall |-> in_valid_ff && out_valid_ff && rsp_stall, "request stalled without a full pipe")
   `KPED_ASSERT(a_advance_fills_out, advance |=> out_valid_ff, "stepped request lost")
   `KPED_ASSERT(a_held_out_keeps_in, (out_valid_ff && rsp_stall && !advance) |=> out_valid_ff, "stalled response dropped")
   `KPED_ASSERT_ALWAYS(a_reset_empties, reset |=> !in_valid_ff && !out_valid_ff, "pipe not empty after reset")

endmodule
